>>> sv/ted_pkg.sv
// package: widths, codes and shared types of the text encoding detector
`timescale 1ns / 1ps
package ted_pkg;

	localparam int ZERO_WINDOW = 4096;
	localparam int HIGH_WINDOW = 8192;
	localparam int COUNT_CAP   = (ZERO_WINDOW > HIGH_WINDOW) ? ZERO_WINDOW : HIGH_WINDOW;

	localparam int COUNT_W  = $clog2(COUNT_CAP + 1);
	localparam int SAMPLE_W = $clog2(ZERO_WINDOW + 1);
	localparam int ZCNT_W   = $clog2((ZERO_WINDOW + 1) / 2 + 1);
	// wide enough for 30 * (zero count + 1) and for the sample
	localparam int CMP_W    = ((ZCNT_W + 5) > SAMPLE_W) ? (ZCNT_W + 5) : SAMPLE_W;

	typedef enum logic [2:0] {
		ENC_NONE     = 3'd0,
		ENC_UTF16LE  = 3'd1,
		ENC_UTF16BE  = 3'd2,
		ENC_UTF8     = 3'd3,
		ENC_CODEPAGE = 3'd4
	} enc_t;

	typedef enum logic [2:0] {
		BY_NONE  = 3'd0,
		BY_BOM   = 3'd1,
		BY_ZEROS = 3'd2,
		BY_UTF8  = 3'd3,
		BY_HIGH  = 3'd4
	} by_t;

	// buffer statistics as they stand after the current byte
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [7:0]         head0;
		logic [7:0]         head1;
		logic [7:0]         head2;
		logic [ZCNT_W-1:0]  zeros_even;
		logic [ZCNT_W-1:0]  zeros_odd;
		logic               high_seen;
	} stats_view_t;

	// utf-8 checker view after the current byte
	typedef struct packed {
		logic broken;
		logic open_seq;
	} utf8_view_t;

endpackage

>>> sv/ted_utf8.sv
// streaming utf-8 validity checker
`timescale 1ns / 1ps
module ted_utf8 import ted_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  logic [7:0] data,
	output utf8_view_t view
);

	logic [1:0] cont_q, cont_d;
	logic [7:0] lead_q, lead_d;
	logic       second_q, second_d;
	logic       broken_q, broken_d;

	always_comb begin
		cont_d   = cont_q;
		lead_d   = lead_q;
		second_d = second_q;
		broken_d = broken_q;
		if (!broken_q) begin
			if (cont_q == 2'd0) begin
				if (data[7]) begin
					if (data[7:5] == 3'b110) begin
						if (data < 8'hC2) begin
							broken_d = 1'b1;
						end else begin
							cont_d   = 2'd1;
							lead_d   = data;
							second_d = 1'b1;
						end
					end else if (data[7:4] == 4'b1110) begin
						cont_d   = 2'd2;
						lead_d   = data;
						second_d = 1'b1;
					end else if (data[7:3] == 5'b11110) begin
						cont_d   = 2'd3;
						lead_d   = data;
						second_d = 1'b1;
					end else begin
						broken_d = 1'b1;
					end
				end
			end else if (data[7:6] != 2'b10) begin
				broken_d = 1'b1;
			end else if (second_q && lead_q == 8'hE0 && data < 8'hA0) begin
				// overlong three-byte form
				broken_d = 1'b1;
			end else if (second_q && lead_q == 8'hF0 && data < 8'h90) begin
				// overlong four-byte form
				broken_d = 1'b1;
			end else begin
				second_d = 1'b0;
				cont_d   = cont_q - 2'd1;
			end
		end
	end

	assign view.broken   = broken_d;
	assign view.open_seq = (cont_d != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q   <= '0;
			lead_q   <= '0;
			second_q <= 1'b0;
			broken_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				cont_q   <= '0;
				lead_q   <= '0;
				second_q <= 1'b0;
				broken_q <= 1'b0;
			end else begin
				cont_q   <= cont_d;
				lead_q   <= lead_d;
				second_q <= second_d;
				broken_q <= broken_d;
			end
		end
	end

	a_broken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q && !(step && last) |=> broken_q)
		else $error("utf-8 broken flag dropped inside a buffer");

endmodule

>>> sv/ted_stats.sv
// byte counter, head bytes, zero counts and high byte flag
`timescale 1ns / 1ps
module ted_stats import ted_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        last,
	input  logic [7:0]  data,
	output stats_view_t view
);

	logic [COUNT_W-1:0] count_q;
	logic [7:0]         head_q [3];
	logic [ZCNT_W-1:0]  zeven_q;
	logic [ZCNT_W-1:0]  zodd_q;
	logic               high_q;

	logic in_zero_win;
	logic is_zero;

	assign in_zero_win = ({1'b0, count_q} < (COUNT_W + 1)'(ZERO_WINDOW));
	assign is_zero     = (data == 8'h00);

	always_comb begin
		view.count      = (count_q < COUNT_W'(COUNT_CAP)) ? count_q + COUNT_W'(1) : count_q;
		view.head0      = (count_q == COUNT_W'(0)) ? data : head_q[0];
		view.head1      = (count_q == COUNT_W'(1)) ? data : head_q[1];
		view.head2      = (count_q == COUNT_W'(2)) ? data : head_q[2];
		view.zeros_even = zeven_q;
		view.zeros_odd  = zodd_q;
		if (in_zero_win && is_zero) begin
			if (count_q[0]) begin
				view.zeros_odd = zodd_q + ZCNT_W'(1);
			end else begin
				view.zeros_even = zeven_q + ZCNT_W'(1);
			end
		end
		view.high_seen = high_q |
			(data[7] & ({1'b0, count_q} < (COUNT_W + 1)'(HIGH_WINDOW)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			head_q[0] <= '0;
			head_q[1] <= '0;
			head_q[2] <= '0;
			zeven_q   <= '0;
			zodd_q    <= '0;
			high_q    <= 1'b0;
		end else if (step) begin
			if (last) begin
				count_q   <= '0;
				head_q[0] <= '0;
				head_q[1] <= '0;
				head_q[2] <= '0;
				zeven_q   <= '0;
				zodd_q    <= '0;
				high_q    <= 1'b0;
			end else begin
				count_q   <= view.count;
				head_q[0] <= view.head0;
				head_q[1] <= view.head1;
				head_q[2] <= view.head2;
				zeven_q   <= view.zeros_even;
				zodd_q    <= view.zeros_odd;
				high_q    <= view.high_seen;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> count_q == '0 && zeven_q == '0 && zodd_q == '0 && !high_q)
		else $error("statistics not cleared after last byte");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && count_q < COUNT_W'(COUNT_CAP) |=> count_q == $past(count_q) + 1'b1)
		else $error("byte counter missed a byte");

endmodule

>>> sv/ted_verdict.sv
// decision logic: byte-order mark, zero heuristic, utf-8 validity, high byte
`timescale 1ns / 1ps
module ted_verdict import ted_pkg::*; (
	input  stats_view_t stats,
	input  utf8_view_t  utf8,
	output enc_t        encoding,
	output by_t         decided_by,
	output logic        utf8_valid
);

	logic [CMP_W-1:0] sample;
	logic [CMP_W-1:0] zodd, zeven;
	logic [CMP_W-1:0] zodd_x6, zeven_x6, zodd_x30, zeven_x30;
	logic             odd_many, even_many, odd_few, even_few;
	logic             long_enough;

	assign sample = ({1'b0, stats.count} >= (COUNT_W + 1)'(ZERO_WINDOW)) ?
		CMP_W'(ZERO_WINDOW) : CMP_W'(stats.count);
	assign zodd  = CMP_W'(stats.zeros_odd);
	assign zeven = CMP_W'(stats.zeros_even);

	// z > s/6 is 6z > s; z < s/30 is 30(z+1) <= s
	assign zodd_x6   = (zodd << 2) + (zodd << 1);
	assign zeven_x6  = (zeven << 2) + (zeven << 1);
	assign zodd_x30  = ((zodd + CMP_W'(1)) << 5) - ((zodd + CMP_W'(1)) << 1);
	assign zeven_x30 = ((zeven + CMP_W'(1)) << 5) - ((zeven + CMP_W'(1)) << 1);

	assign odd_many  = zodd_x6 > sample;
	assign even_many = zeven_x6 > sample;
	assign odd_few   = zodd_x30 <= sample;
	assign even_few  = zeven_x30 <= sample;

	assign utf8_valid  = !(utf8.broken || utf8.open_seq);
	assign long_enough = stats.count >= COUNT_W'(2);

	always_comb begin
		encoding   = ENC_NONE;
		decided_by = BY_NONE;
		if (long_enough) begin
			if (stats.head0 == 8'hFF && stats.head1 == 8'hFE) begin
				encoding   = ENC_UTF16LE;
				decided_by = BY_BOM;
			end else if (stats.head0 == 8'hFE && stats.head1 == 8'hFF) begin
				encoding   = ENC_UTF16BE;
				decided_by = BY_BOM;
			end else if (stats.count >= COUNT_W'(3) && stats.head0 == 8'hEF &&
					stats.head1 == 8'hBB && stats.head2 == 8'hBF) begin
				encoding   = ENC_UTF8;
				decided_by = BY_BOM;
			end else if (odd_many && even_few) begin
				encoding   = ENC_UTF16LE;
				decided_by = BY_ZEROS;
			end else if (even_many && odd_few) begin
				encoding   = ENC_UTF16BE;
				decided_by = BY_ZEROS;
			end else if (utf8_valid) begin
				encoding   = ENC_UTF8;
				decided_by = BY_UTF8;
			end else if (stats.high_seen) begin
				encoding   = ENC_CODEPAGE;
				decided_by = BY_HIGH;
			end
		end
	end

endmodule

>>> sv/text_encoding_detector_top.sv
// top level of the text encoding detector
`timescale 1ns / 1ps
// Text encoding detector. Bytes of a buffer stream in one per transfer, the
// final byte flagged by last_byte; that byte yields one result transfer with
// the encoding verdict, the rule that decided it and the utf-8 validity flag.
// Other bytes yield nothing. The block takes one byte every cycle unless the
// stall below holds it: a byte sits in the input register until the edge at which
// the statistics and utf-8 checker update, and the verdict is captured in the
// output register at that same edge, so out_valid rises as the last byte leaves
// the input register and the result waits there for out_ready. The only stall comes
// from the output side: a last byte waits in the input register while an
// earlier result is still not taken, and then in_ready follows out_ready.
// After each last byte all statistics return to their reset values, so the next
// byte opens a new buffer.
module text_encoding_detector_top import ted_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] encoding,
	output logic [2:0] decided_by,
	output logic       utf8_valid
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic       out_valid_q;
	logic [2:0] encoding_q;
	logic [2:0] decided_by_q;
	logic       utf8_valid_q;

	logic        s1_go;
	logic        out_free;
	stats_view_t stats;
	utf8_view_t  utf8;
	enc_t        enc_d;
	by_t         by_d;
	logic        valid_d;

	// result slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// plain bytes always move on; a last byte needs the result slot
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;

	ted_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.last   (last_s1),
		.data   (byte_s1),
		.view   (stats)
	);

	ted_utf8 u_utf8 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.last   (last_s1),
		.data   (byte_s1),
		.view   (utf8)
	);

	ted_verdict u_verdict (
		.stats      (stats),
		.utf8       (utf8),
		.encoding   (enc_d),
		.decided_by (by_d),
		.utf8_valid (valid_d)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			encoding_q   <= enc_d;
			decided_by_q <= by_d;
			utf8_valid_q <= valid_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign encoding   = encoding_q;
	assign decided_by = decided_by_q;
	assign utf8_valid = utf8_valid_q;

	// a verdict of none goes with a decider of none, and only then
	a_none_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((encoding_q == ENC_NONE) == (decided_by_q == BY_NONE)))
		else $error("encoding and decider disagree on none");

	// a utf-8 validity verdict requires a valid buffer
	a_utf8_rule: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && decided_by_q == BY_UTF8 |-> utf8_valid_q && encoding_q == ENC_UTF8)
		else $error("utf-8 rule decided on an invalid buffer");

	// a last byte leaving the input register always produces a result
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> out_valid_q)
		else $error("last byte left no result");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(s1_go && last_s1))
		else $error("pending result overwritten");

endmodule
